FILE: rtl/ftar_pkg.sv
`timescale 1ns / 1ps
package ftar_pkg;

    // Field and datapath widths
    localparam int DIM_W   = 9;   // configured dimension, 1..MAX_DIM
    localparam int MAX_DIM = 256;
    localparam int COL_W   = 9;   // output column, includes the newline position
    localparam int ROW_W   = 8;   // output row
    localparam int SAMP_W  = 8;   // saturated source column or row
    localparam int ADDR_W  = 16;  // level store address
    localparam int DIV_W   = 17;  // dividend and quotient of the sampling divider
    localparam int LEVEL_W = 7;
    localparam int CHAR_W  = 7;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;

    // Brightness quantizer: level = 85 - floor(sum / 9), sum <= 765
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 7'd85;
    localparam logic [9:0]         RECIP_NINE = 10'd911;  // ceil(2^13 / 9)
    localparam int                 RECIP_SHIFT = 13;
    localparam int                 GLYPH_COUNT = 86;

    localparam logic [CHAR_W-1:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        7'd32,  7'd96,  7'd46,  7'd45,  7'd39,  7'd58,  7'd95,  7'd44,  7'd94,  7'd61,
        7'd59,  7'd62,  7'd43,  7'd33,  7'd114, 7'd99,  7'd47,  7'd122, 7'd63,  7'd115,
        7'd76,  7'd84,  7'd118, 7'd41,  7'd74,  7'd55,  7'd40,  7'd124, 7'd70,  7'd123,
        7'd67,  7'd102, 7'd73,  7'd51,  7'd49,  7'd116, 7'd108, 7'd117, 7'd91,  7'd110,
        7'd101, 7'd111, 7'd90,  7'd53,  7'd89,  7'd120, 7'd106, 7'd121, 7'd97,  7'd50,
        7'd69,  7'd83,  7'd119, 7'd107, 7'd80,  7'd54,  7'd104, 7'd57,  7'd100, 7'd52,
        7'd86,  7'd112, 7'd79,  7'd71,  7'd98,  7'd85,  7'd65,  7'd88,  7'd72,  7'd109,
        7'd56,  7'd82,  7'd68,  7'd35,  7'd36,  7'd66,  7'd103, 7'd48,  7'd77,  7'd78,
        7'd87,  7'd81,  7'd37,  7'd38,  7'd64,  7'd64
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              frame_end;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
    } t_cfg;

    // Sampler status toward the top level
    typedef struct packed {
        logic              ready;  // step values valid, fetch may be taken
        logic              glyph;  // next fetch yields a glyph, else a newline
        logic              last;   // a newline now ends the frame
        logic [ADDR_W-1:0] idx;    // level store address of the next glyph
    } t_samp;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of(input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b);
        logic [9:0]  s;
        logic [19:0] p;
        s = {2'b00, r} + {2'b00, g} + {2'b00, b};
        p = 20'(s) * 20'(RECIP_NINE);
        return LEVEL_TOP - p[RECIP_SHIFT +: LEVEL_W];
    endfunction

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] l;
        l = (level >= LEVEL_W'(GLYPH_COUNT)) ? LEVEL_W'(GLYPH_COUNT - 1) : level;
        return GLYPH_ROM[l];
    endfunction

endpackage

FILE: rtl/ftar_level_ram.sv
`timescale 1ns / 1ps
module ftar_level_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ftar_divider.sv
`timescale 1ns / 1ps
module ftar_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ftar_pkg::DIV_W-1:0] i_dividend,
    input  logic [ftar_pkg::DIM_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [ftar_pkg::DIV_W-1:0] o_quot,
    output logic [ftar_pkg::DIM_W-1:0] o_rem
);
    import ftar_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quot;
    logic [DIM_W-1:0] r_rem;
    logic [DIM_W-1:0] r_div;

    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quot[DIV_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], fits};
            r_rem  <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/ftar_sampler.sv
`timescale 1ns / 1ps
module ftar_sampler (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ftar_pkg::t_cfg i_cfg,
    input  logic           i_cfg_wr,
    input  logic           i_fetch,
    output ftar_pkg::t_samp o_samp
);
    import ftar_pkg::*;

    typedef enum logic [5:0] {
        SM_START_STEP = 6'b000001,
        SM_WAIT_STEP  = 6'b000010,
        SM_START_POS  = 6'b000100,
        SM_WAIT_POS   = 6'b001000,
        SM_SETTLE     = 6'b010000,
        SM_READY      = 6'b100000
    } t_sm_state;

    t_sm_state r_state, n_state;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [DIV_W-1:0]  r_sx, r_sy;
    logic [DIM_W-1:0]  r_remx, r_remy;
    logic [DIM_W-1:0]  r_qx, r_rx, r_qy, r_ry;
    logic [ADDR_W-1:0] r_idx;

    logic              div_start;
    logic [DIV_W-1:0]  dvd_x, dvd_y;
    logic              done_x, done_y;
    logic [DIV_W-1:0]  quot_x, quot_y;
    logic [DIM_W-1:0]  rem_x, rem_y;

    logic              glyph, last;
    logic [DIM_W:0]    sum_x, sum_y;
    logic              carry_x, carry_y;
    logic [DIV_W-1:0]  n_sx, n_sy;
    logic [DIM_W-1:0]  n_remx, n_remy;
    logic [SAMP_W-1:0] sx_sat, sy_sat;
    logic [SAMP_W-1:0] src_row;
    logic [DIV_W-1:0]  row_base;
    logic [DIV_W-1:0]  n_idx;
    logic [2*DIM_W-1:0] prod_x;
    logic [ROW_W+DIM_W-1:0] prod_y;

    // Divider operands: step ratio first, then current position
    always_comb begin
        prod_x = DIM_W'(r_col) * i_cfg.src_width;
        prod_y = r_row * i_cfg.src_height;
        if (r_state == SM_START_POS) begin
            dvd_x = prod_x[DIV_W-1:0];
            dvd_y = DIV_W'(prod_y);
        end else begin
            dvd_x = DIV_W'(i_cfg.src_width);
            dvd_y = DIV_W'(i_cfg.src_height);
        end
        div_start = (r_state == SM_START_STEP) || (r_state == SM_START_POS);
    end

    ftar_divider u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_x),
        .i_divisor  (i_cfg.out_width),
        .o_done     (done_x),
        .o_quot     (quot_x),
        .o_rem      (rem_x)
    );

    ftar_divider u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_y),
        .i_divisor  (i_cfg.out_height),
        .o_done     (done_y),
        .o_quot     (quot_y),
        .o_rem      (rem_y)
    );

    // Advance the source position by one output step
    always_comb begin
        glyph   = (DIM_W'(r_col) < i_cfg.out_width);
        last    = ({1'b0, r_row} + DIM_W'(1)) >= i_cfg.out_height;
        sum_x   = {1'b0, r_remx} + {1'b0, r_rx};
        sum_y   = {1'b0, r_remy} + {1'b0, r_ry};
        carry_x = (sum_x >= {1'b0, i_cfg.out_width});
        carry_y = (sum_y >= {1'b0, i_cfg.out_height});
        n_remx  = carry_x ? DIM_W'(sum_x - {1'b0, i_cfg.out_width}) : sum_x[DIM_W-1:0];
        n_remy  = carry_y ? DIM_W'(sum_y - {1'b0, i_cfg.out_height}) : sum_y[DIM_W-1:0];
        n_sx    = r_sx + DIV_W'(r_qx) + DIV_W'(carry_x);
        n_sy    = r_sy + DIV_W'(r_qy) + DIV_W'(carry_y);
    end

    // Saturate the sample and flip rows for the bottom-up store
    always_comb begin
        sx_sat   = (r_sx >= DIV_W'(i_cfg.src_width)) ? SAMP_W'(i_cfg.src_width - DIM_W'(1))
                                                     : r_sx[SAMP_W-1:0];
        sy_sat   = (r_sy >= DIV_W'(i_cfg.src_height)) ? SAMP_W'(i_cfg.src_height - DIM_W'(1))
                                                      : r_sy[SAMP_W-1:0];
        src_row  = SAMP_W'(i_cfg.src_height - DIM_W'(1) - {1'b0, sy_sat});
        row_base = src_row * i_cfg.src_width;
        n_idx    = row_base + DIV_W'(sx_sat);
    end

    // Recompute sequence, restarted by any register write
    always_comb begin
        n_state = r_state;
        case (r_state)
            SM_START_STEP: n_state = SM_WAIT_STEP;
            SM_WAIT_STEP:  if (done_x) n_state = SM_START_POS;
            SM_START_POS:  n_state = SM_WAIT_POS;
            SM_WAIT_POS:   if (done_x) n_state = SM_SETTLE;
            SM_SETTLE:     n_state = SM_READY;
            SM_READY:      n_state = SM_READY;
            default:       n_state = SM_START_STEP;
        endcase
        if (i_cfg_wr) begin
            n_state = SM_START_STEP;
        end
    end

    // State and output position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SM_START_STEP;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (i_fetch) begin
                if (glyph) begin
                    r_col <= r_col + COL_W'(1);
                end else begin
                    r_col <= '0;
                    r_row <= last ? '0 : r_row + ROW_W'(1);
                end
            end
        end
    end

    // Step ratios, source position and registered address
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx[ADDR_W-1:0];
        if (r_state == SM_WAIT_STEP && done_x) begin
            r_qx <= quot_x[DIM_W-1:0];
            r_rx <= rem_x;
            r_qy <= quot_y[DIM_W-1:0];
            r_ry <= rem_y;
        end
        if (r_state == SM_WAIT_POS && done_x) begin
            r_sx   <= quot_x;
            r_remx <= rem_x;
            r_sy   <= quot_y;
            r_remy <= rem_y;
        end else if (i_fetch) begin
            if (glyph) begin
                r_sx   <= n_sx;
                r_remx <= n_remx;
            end else begin
                r_sx   <= '0;
                r_remx <= '0;
                if (last) begin
                    r_sy   <= '0;
                    r_remy <= '0;
                end else begin
                    r_sy   <= n_sy;
                    r_remy <= n_remy;
                end
            end
        end
    end

    assign o_samp.ready = (r_state == SM_READY);
    assign o_samp.glyph = glyph;
    assign o_samp.last  = last;
    assign o_samp.idx   = r_idx;

    a_fetch_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fetch |-> (r_state == SM_READY))
        else $error("fetch taken while sampling steps are being recomputed");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SM_READY) |-> (r_remx < i_cfg.out_width) && (r_remy < i_cfg.out_height))
        else $error("sampling remainder out of range");

endmodule

FILE: rtl/frame_to_ascii_art_renderer_top.sv
`timescale 1ns / 1ps
// Renders a stored bottom-up RGB frame as ASCII art. A load item stores the
// palette level of one pixel at the next address of a 65536 x 7 level memory
// (no clearing; unloaded entries read as garbage). A fetch item returns the next
// character, top row first, with nearest-neighbor sampling and a newline after
// each row; frame_end marks the newline of the last row. A load is written to
// the level memory when accepted; a fetch result passes the memory's read
// register and then the output register, and no item is taken while a fetch
// is pending. Each sampled position advances by a precomputed ratio and
// remainder, so after reset and every register write, ready is low while two
// serial 17-bit dividers rebuild the step ratios and the current source position.
module frame_to_ascii_art_renderer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ftar_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ftar_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [ftar_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ftar_pkg::DIM_W-1:0]    i_cfg_data
);
    import ftar_pkg::*;

    t_cfg              r_cfg;
    t_samp             samp;
    logic [ADDR_W-1:0] r_load_pos;
    logic              r_pend;
    logic              r_pend_nl;
    logic              r_pend_end;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              accept;
    logic              do_load;
    logic              do_fetch;
    logic              move;
    logic [LEVEL_W-1:0] rdata;

    // Handshake decode
    always_comb begin
        o_in_ready = !r_pend && samp.ready;
        accept     = i_in_valid && o_in_ready;
        do_load    = accept && (i_in_data.cmd == CMD_LOAD);
        do_fetch   = accept && (i_in_data.cmd == CMD_FETCH);
        move       = r_pend && (!r_out_valid || i_out_ready);
    end

    // Configuration registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= DIM_W'(1);
            r_cfg.src_height <= DIM_W'(1);
            r_cfg.out_width  <= DIM_W'(1);
            r_cfg.out_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_cfg.src_width  <= clamp_dim(i_cfg_data);
                CFG_SRC_HEIGHT: r_cfg.src_height <= clamp_dim(i_cfg_data);
                CFG_OUT_WIDTH:  r_cfg.out_width  <= clamp_dim(i_cfg_data);
                CFG_OUT_HEIGHT: r_cfg.out_height <= clamp_dim(i_cfg_data);
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    ftar_sampler u_sampler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (i_cfg_we),
        .i_fetch  (do_fetch),
        .o_samp   (samp)
    );

    ftar_level_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (LEVEL_W)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (r_load_pos),
        .i_wdata (level_of(i_in_data.red, i_in_data.green, i_in_data.blue)),
        .i_re    (do_fetch && samp.glyph),
        .i_raddr (samp.idx),
        .o_rdata (rdata)
    );

    // Load address and pending fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (do_load) begin
                r_load_pos <= r_load_pos + ADDR_W'(1);
            end
            if (do_fetch) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_fetch) begin
            r_pend_nl  <= !samp.glyph;
            r_pend_end <= !samp.glyph && samp.last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data.character <= r_pend_nl ? NEWLINE_CODE : glyph_of(rdata);
            r_out_data.frame_end <= r_pend_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_fetch_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_fetch |=> r_pend)
        else $error("fetch item left no pending result");

    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_pend))
        else $error("result appeared without a pending fetch");

endmodule
